FILE: rtl/prc_pkg.sv
// polygon clipper package: shared constants and vertex type
// no dependencies
`default_nettype none
package prc_pkg;
  localparam int XW = 24;
  localparam int UW = 20;
  localparam int CW = 8;
  localparam int VW = 2 * XW + 2 * UW + 4 * CW;
  localparam int TW = 17;
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_LEFT = 3'd1;
  localparam logic [2:0] REG_TOP = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  typedef struct packed {
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] g;
    logic [CW-1:0] r;
    logic signed [UW-1:0] v;
    logic signed [UW-1:0] u;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] x;
  } vtx_t;
endpackage
`default_nettype wire

FILE: rtl/prc_ram.sv
// generic single-port-write, one-read synchronous ram, registered read
// no dependencies
`default_nettype none
module prc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/polygon_rect_clipper.sv
// polygon clipper: loads a vertex list, clips it in four passes, emits the result
// each pass over 2 or more vertices reads and classifies every stored vertex; a crossing
// adds a serial divide and 8 lerp steps; emit reads each result from the store in turn;
// one polygon in flight; loading accepts one vertex a cycle; the final vertex starts clipping
// reset (rst_n low, synchronous) clears counts, flags, config registers and the state machine
// memory contents are undefined after reset and need no clearing pass
`default_nettype none
module polygon_rect_clipper import prc_pkg::*; #(
  parameter int MAX_VERTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [19:0] in_tex_u,
  input  wire logic signed [19:0] in_tex_v,
  input  wire logic [7:0]        in_red,
  input  wire logic [7:0]        in_green,
  input  wire logic [7:0]        in_blue,
  input  wire logic [7:0]        in_alpha,
  input  wire logic              in_last_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [23:0]     out_x,
  output logic signed [23:0]     out_y,
  output logic signed [19:0]     out_u,
  output logic signed [19:0]     out_v,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic [7:0]             out_alpha,
  output logic                   out_vertex_valid,
  output logic                   out_drawable,
  output logic                   out_overflow,
  output logic                   out_last_out
);
  localparam int AW = $clog2(MAX_VERTS);
  localparam int NW = $clog2(MAX_VERTS + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_VERTS);
  localparam logic [NW-1:0] CAP = (MAX_VERTS > 64) ? NW'(64) : NW'(MAX_VERTS);

  typedef enum logic [3:0] {
    S_LOAD, S_PSTART, S_RDA, S_RDB, S_CLS, S_DIV, S_LERP, S_PUSH,
    S_PUSHB, S_NEXT, S_EMRD, S_EMIT, S_EMPTY
  } state_t;

  // configuration registers
  logic        mode_r;
  logic signed [15:0] left_r, top_r;
  logic [14:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; left_r <= '0; top_r <= '0; width_r <= '0; height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r <= cfg_data[0];
        REG_LEFT:   left_r <= cfg_data;
        REG_TOP:    top_r <= cfg_data;
        REG_WIDTH:  width_r <= cfg_data[14:0];
        REG_HEIGHT: height_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // two vertex stores, ping-pong between passes
  logic          we_a, we_b;
  logic [AW-1:0] wa_a, wa_b, ra_a, ra_b;
  vtx_t          wd;
  logic [VW-1:0] rd_a, rd_b;

  prc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_ram_a (
    .clk, .we(we_a), .waddr(wa_a), .wdata(wd), .raddr(ra_a), .rdata(rd_a));
  prc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_ram_b (
    .clk, .we(we_b), .waddr(wa_b), .wdata(wd), .raddr(ra_b), .rdata(rd_b));

  state_t        state_r;
  logic [NW-1:0] cnt_a_r, cnt_b_r;
  logic          ovf_r;
  logic [1:0]    pass_r;
  logic          src_r;            // 0: a is source, 1: b is source
  logic [NW-1:0] idx_r;            // edge index; 0 is the closing edge
  vtx_t          va_r, vb_r, vm_r;
  logic          oa_r, ob_r;
  logic [NW-1:0] ecnt_r, ei_r;
  logic          eovf_r, edraw_r;

  // serial divider for t
  logic [31:0]   num_r, den_r;
  logic [32:0]   rem_r;
  logic [TW-1:0] q_r;
  logic [4:0]    dstep_r;
  logic [3:0]    lstep_r;

  // pass geometry
  logic          upper, use_y;
  logic signed [25:0] bound;
  assign upper = pass_r[1];
  assign use_y = pass_r[0];
  always_comb begin
    if (mode_r) begin
      bound = upper ? 26'sd65536 : 26'sd0;
    end else if (!use_y) begin
      bound = upper ? 26'((17'(left_r) + 17'($signed({1'b0, width_r}))) * 256)
                    : 26'(left_r * 256);
    end else begin
      bound = upper ? 26'((17'(top_r) + 17'($signed({1'b0, height_r}))) * 256)
                    : 26'(top_r * 256);
    end
  end

  function automatic logic signed [25:0] coord(vtx_t v, logic m, logic yy);
    if (m) return yy ? 26'(v.v) : 26'(v.u);
    return yy ? 26'(v.y) : 26'(v.x);
  endfunction

  logic signed [25:0] ca, cb;
  assign ca = coord(va_r, mode_r, use_y);
  assign cb = coord(vb_r, mode_r, use_y);

  logic [NW-1:0] src_n, dst_n;
  assign src_n = src_r ? cnt_b_r : cnt_a_r;
  assign dst_n = src_r ? cnt_a_r : cnt_b_r;
  logic [VW-1:0] rd_src;
  assign rd_src = src_r ? rd_b : rd_a;

  // lerp one field per step: f1 + trunc0(t*(f2-f1)>>16)
  logic signed [25:0] f1, f2;
  always_comb begin
    case (lstep_r)
      4'd0: begin f1 = 26'(va_r.x); f2 = 26'(vb_r.x); end
      4'd1: begin f1 = 26'(va_r.y); f2 = 26'(vb_r.y); end
      4'd2: begin f1 = 26'(va_r.u); f2 = 26'(vb_r.u); end
      4'd3: begin f1 = 26'(va_r.v); f2 = 26'(vb_r.v); end
      4'd4: begin f1 = 26'($signed({1'b0, va_r.r})); f2 = 26'($signed({1'b0, vb_r.r})); end
      4'd5: begin f1 = 26'($signed({1'b0, va_r.g})); f2 = 26'($signed({1'b0, vb_r.g})); end
      4'd6: begin f1 = 26'($signed({1'b0, va_r.b})); f2 = 26'($signed({1'b0, vb_r.b})); end
      default: begin f1 = 26'($signed({1'b0, va_r.a})); f2 = 26'($signed({1'b0, vb_r.a})); end
    endcase
  end
  logic signed [25:0] dlt, lres;
  logic [25:0]        dmag;
  logic [42:0]        prod;
  assign dlt  = f2 - f1;
  assign dmag = dlt[25] ? 26'(-dlt) : 26'(dlt);
  assign prod = 43'(dmag) * 43'(q_r);
  assign lres = dlt[25] ? f1 - 26'(prod[42:16]) : f1 + 26'(prod[42:16]);

  // outside tests on the loaded pair
  logic outa, outb;
  assign outa = upper ? (ca >= bound) : (ca < bound);
  assign outb = upper ? (cb >= bound) : (cb < bound);

  // push helper
  logic          push;
  vtx_t          push_v;
  logic          full;
  assign full = (dst_n >= NMAX);

  logic load_acc;
  assign in_ready = (state_r == S_LOAD);
  assign load_acc = in_valid && in_ready;

  always_comb begin
    we_a = 1'b0; we_b = 1'b0;
    wa_a = cnt_a_r[AW-1:0]; wa_b = cnt_b_r[AW-1:0];
    wd = push_v;
    push = (state_r == S_PUSH) || (state_r == S_PUSHB);
    push_v = (state_r == S_PUSHB || ((state_r == S_PUSH) && !oa_r && !ob_r)) ? vb_r : vm_r;
    if (state_r == S_LOAD) begin
      push_v = '{a: in_alpha, b: in_blue, g: in_green, r: in_red, v: in_tex_v,
                 u: in_tex_u, y: in_pos_y, x: in_pos_x};
      wd = push_v;
      we_a = load_acc && (cnt_a_r < NMAX);
    end else if (push && !full) begin
      we_a = src_r; we_b = !src_r;
    end
  end

  // read addresses: closing edge reads n-1 then 0, edge i reads only i (vertex i-1 is kept)
  always_comb begin
    ra_a = '0; ra_b = '0;
    if (state_r == S_EMRD) begin
      ra_a = ei_r[AW-1:0];
    end else begin
      ra_a = (state_r == S_PSTART) ? AW'(src_n - 1'b1) : idx_r[AW-1:0];
      ra_b = ra_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_a_r <= '0; cnt_b_r <= '0; ovf_r <= 1'b0;
      pass_r <= '0; src_r <= 1'b0; idx_r <= '0; out_valid <= 1'b0;
      ecnt_r <= '0; ei_r <= '0; eovf_r <= 1'b0; edraw_r <= 1'b0;
      dstep_r <= '0; lstep_r <= '0;
    end else begin
      if (push) begin
        if (full) ovf_r <= 1'b1;
        else if (src_r) cnt_a_r <= cnt_a_r + 1'b1;
        else cnt_b_r <= cnt_b_r + 1'b1;
      end
      case (state_r)
        S_LOAD: if (load_acc) begin
          if (cnt_a_r < NMAX) cnt_a_r <= cnt_a_r + 1'b1;
          else ovf_r <= 1'b1;
          if (in_last_in) begin
            pass_r <= '0; src_r <= 1'b0; state_r <= S_PSTART;
          end
        end
        S_PSTART: begin
          // the read of vertex n-1 is issued here
          if (src_r) cnt_a_r <= '0; else cnt_b_r <= '0;
          idx_r <= '0;
          state_r <= (src_n < 2) ? S_NEXT : S_RDA;
        end
        S_RDA: begin
          va_r <= rd_src;
          state_r <= S_RDB;
        end
        S_RDB: state_r <= S_CLS;   // read of vertex idx is in flight
        S_CLS: begin
          vb_r <= rd_src;
          state_r <= S_LERP;
          lstep_r <= 4'd15;
        end
        S_LERP: begin
          if (lstep_r == 4'd15) begin
            // classify, set up the divide
            oa_r <= outa; ob_r <= outb;
            num_r <= 32'((bound - ca) < 0 ? ca - bound : bound - ca);
            den_r <= 32'((cb - ca) < 0 ? ca - cb : cb - ca);
            rem_r <= '0; q_r <= '0; dstep_r <= 5'd0;
            if (outa == outb) begin
              state_r <= outa ? S_NEXT : S_PUSH;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            case (lstep_r)
              4'd0: vm_r.x <= lres[XW-1:0];
              4'd1: vm_r.y <= lres[XW-1:0];
              4'd2: vm_r.u <= lres[UW-1:0];
              4'd3: vm_r.v <= lres[UW-1:0];
              4'd4: vm_r.r <= lres[CW-1:0];
              4'd5: vm_r.g <= lres[CW-1:0];
              4'd6: vm_r.b <= lres[CW-1:0];
              default: vm_r.a <= lres[CW-1:0];
            endcase
            if (lstep_r == 4'd7) state_r <= S_PUSH;
            lstep_r <= lstep_r + 1'b1;
          end
        end
        S_DIV: begin
          // restoring divide of num<<16 by den, one quotient bit a cycle
          if (den_r == '0) begin
            q_r <= '0; lstep_r <= '0; state_r <= S_LERP;
          end else if (dstep_r == 5'd17) begin
            if (q_r > TW'(65536) || num_r >= den_r) q_r <= TW'(65536);
            lstep_r <= '0; state_r <= S_LERP;
          end else begin
            logic [32:0] tr;
            tr = {rem_r[31:0], (dstep_r == 5'd0) ? 1'b0 : 1'b0};
            if (dstep_r == 5'd0) tr = 33'(num_r);
            if (dstep_r == 5'd0) begin
              // num < den here unless t saturates, handled at the end
              rem_r <= 33'(num_r);
            end else if (tr >= 33'(den_r)) begin
              rem_r <= tr - 33'(den_r); q_r <= {q_r[TW-2:0], 1'b1};
            end else begin
              rem_r <= tr; q_r <= {q_r[TW-2:0], 1'b0};
            end
            dstep_r <= dstep_r + 1'b1;
          end
        end
        S_PUSH: state_r <= (oa_r && !ob_r) ? S_PUSHB : S_NEXT;
        S_PUSHB: state_r <= S_NEXT;
        S_NEXT: begin
          if (src_n >= 2 && idx_r + 1'b1 < src_n) begin
            idx_r <= idx_r + 1'b1;
            va_r <= vb_r;
            state_r <= S_RDB;
          end else if (pass_r == 2'd3) begin
            ecnt_r <= cnt_a_r; ei_r <= '0;
            eovf_r <= ovf_r || (cnt_a_r > CAP);
            edraw_r <= (cnt_a_r >= 3);
            state_r <= (cnt_a_r == '0) ? S_EMPTY : S_EMRD;
          end else begin
            pass_r <= pass_r + 1'b1; src_r <= !src_r; state_r <= S_PSTART;
          end
        end
        S_EMRD: state_r <= S_EMIT;
        S_EMIT: begin
          if (!out_valid) begin
            {out_alpha, out_blue, out_green, out_red, out_v, out_u, out_y, out_x} <= rd_a;
            out_vertex_valid <= 1'b1; out_drawable <= edraw_r; out_overflow <= eovf_r;
            out_last_out <= (ei_r + 1'b1 == ecnt_r) || (ei_r + 1'b1 == CAP);
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last_out) begin
              cnt_a_r <= '0; cnt_b_r <= '0; ovf_r <= 1'b0; state_r <= S_LOAD;
            end else begin
              ei_r <= ei_r + 1'b1; state_r <= S_EMRD;
            end
          end
        end
        S_EMPTY: begin
          if (!out_valid) begin
            {out_alpha, out_blue, out_green, out_red, out_v, out_u, out_y, out_x} <= '0;
            out_vertex_valid <= 1'b0; out_drawable <= 1'b0; out_overflow <= eovf_r;
            out_last_out <= 1'b1; out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            cnt_a_r <= '0; cnt_b_r <= '0; ovf_r <= 1'b0; state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/prc_checker.sv
// port-level checker for the polygon clipper, bound to the top level
// depends on polygon_rect_clipper ports only
`default_nettype none
module prc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_vertex_valid,
  input wire logic out_drawable,
  input wire logic out_last_out
);
  // no new vertex taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during emit");
  // an empty result is always final
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vertex_valid |-> out_last_out) else $error("empty not last");
  // an empty result is never drawable
  a_empty_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vertex_valid |-> !out_drawable) else $error("empty drawable");
  // a waiting result stays valid while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind polygon_rect_clipper prc_checker u_prc_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_vertex_valid, .out_drawable, .out_last_out);
`default_nettype wire
